// ===== rtl/text_mode_console_writer_assert.svh =====
// ----------------------------------------------------------------------------
// text_mode_console_writer_assert.svh
// assertion macros used by the console writer rtl
// ----------------------------------------------------------------------------
`ifndef TEXT_MODE_CONSOLE_WRITER_ASSERT_SVH
`define TEXT_MODE_CONSOLE_WRITER_ASSERT_SVH

// property that must hold at every clock edge out of reset
`define CTW_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) else $error(msg);

// implication checked at every clock edge out of reset
`define CTW_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== rtl/ctw_pkg.sv =====
// ----------------------------------------------------------------------------
// ctw_pkg
// shared codes and types of the text mode console writer
// ----------------------------------------------------------------------------
package ctw_pkg;

    localparam int CHAR_W     = 8;
    localparam int IN_ADDR_W  = 11;
    localparam int OUT_COL_W  = 7;
    localparam int OUT_ROW_W  = 5;
    localparam int S_TDATA_W  = 32;
    localparam int M_TDATA_W  = 40;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    localparam logic [CHAR_W-1:0] CODE_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0] CODE_BACKSPACE = 8'd8;

    // what a write item does to the screen cell at the cursor
    typedef enum logic [1:0] {
        CELL_NONE,
        CELL_STORE,
        CELL_ERASE
    } cell_op_t;

endpackage

// ===== rtl/ctw_cursor_step.sv =====
// ----------------------------------------------------------------------------
// ctw_cursor_step
// next write cursor and target cell for one character of a write item
// ----------------------------------------------------------------------------
module ctw_cursor_step #(
    parameter int COLUMNS = 80,
    parameter int COL_W   = 7,
    parameter int ROW_W   = 5,
    parameter int ADDR_W  = 11
) (
    input  logic [COL_W-1:0]         cur_col,
    input  logic [ROW_W-1:0]         cur_row,
    input  logic [ctw_pkg::CHAR_W-1:0] char_code,
    output logic [COL_W-1:0]         nxt_col,
    output logic [ROW_W-1:0]         nxt_row,
    output logic [ADDR_W-1:0]        cell_idx,
    output ctw_pkg::cell_op_t        cell_op
);
    import ctw_pkg::*;

    logic [COL_W-1:0] sel_col;
    logic [ROW_W-1:0] sel_row;
    logic             col_zero;
    logic             col_last;

    assign col_zero = (cur_col == '0);
    assign col_last = (cur_col == COL_W'(COLUMNS - 1));

    always_comb begin
        nxt_col = cur_col;
        nxt_row = cur_row;
        sel_col = cur_col;
        sel_row = cur_row;
        cell_op = CELL_NONE;
        priority if (char_code == CODE_NEWLINE) begin
            nxt_col = '0;
            nxt_row = cur_row + ROW_W'(1);
        end else if (char_code == CODE_BACKSPACE) begin
            if (!(col_zero && cur_row == '0)) begin
                if (col_zero) begin
                    nxt_col = COL_W'(COLUMNS - 1);
                    nxt_row = cur_row - ROW_W'(1);
                end else begin
                    nxt_col = cur_col - COL_W'(1);
                end
                sel_col = nxt_col;
                sel_row = nxt_row;
                cell_op = CELL_ERASE;
            end
        end else begin
            cell_op = CELL_STORE;
            if (col_last) begin
                nxt_col = '0;
                nxt_row = cur_row + ROW_W'(1);
            end else begin
                nxt_col = cur_col + COL_W'(1);
            end
        end
    end

    // row * columns + column of the cell that is touched
    assign cell_idx = ADDR_W'(ADDR_W'(sel_row) * ADDR_W'(COLUMNS)) + ADDR_W'(sel_col);

endmodule

// ===== rtl/text_mode_console_writer.sv =====
// ----------------------------------------------------------------------------
// text_mode_console_writer
// character-cell console: screen memory, write cursor and shown cursor
// ----------------------------------------------------------------------------
// Input items arrive on s_tvalid/s_tready/s_tdata; s_tuser selects a write
// (0) or a cell read (1), s_tlast marks the last character of a string and
// latches the shown cursor. Each item yields one result on m_tvalid/m_tready/
// m_tdata carrying the read cell (zero for writes and for reads out of range)
// and both cursors. After reset a clearing pass zeroes the screen memory,
// one cell a cycle, with s_tready low. A read item goes from idle straight
// to the final state; a write passes through the calc state first.
// A write that finds the cursor row at ROWS first scrolls: one pass of the
// sequencer over the memory, one cell per cycle through the single read port
// and the single write port. One item is in work at a time.
// The result sits in an output register; the next item can be accepted while
// it waits, and a stalled receiver holds the block in its final state until
// the register frees up.
// ----------------------------------------------------------------------------
`include "text_mode_console_writer_assert.svh"

module text_mode_console_writer #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // char_code[7:0], char_color[15:8], read_address[26:16], zero fill[31:27]
    input  logic [ctw_pkg::S_TDATA_W-1:0]  s_tdata,
    // operation
    input  logic                           s_tuser,
    // last_char
    input  logic                           s_tlast,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // cell_char[7:0], cell_color[15:8], cursor_column[22:16], cursor_row[27:23],
    // shown_column[34:28], shown_row[39:35]
    output logic [ctw_pkg::M_TDATA_W-1:0]  m_tdata
);
    import ctw_pkg::*;

    localparam int CELLS  = COLUMNS * ROWS;
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ROW_W  = $clog2(ROWS + 1);
    localparam int ADDR_W = $clog2(CELLS);
    localparam int CELL_W = 2 * CHAR_W;

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_SCROLL = 3'd2;
    localparam logic [2:0] ST_CALC   = 3'd3;
    localparam logic [2:0] ST_DONE   = 3'd4;

    localparam logic [1:0] WSEL_ZERO  = 2'd0;
    localparam logic [1:0] WSEL_COPY  = 2'd1;
    localparam logic [1:0] WSEL_CHAR  = 2'd2;
    localparam logic [1:0] WSEL_ERASE = 2'd3;

    logic [CELL_W-1:0] screen_mem [CELLS];

    logic [2:0]        state_reg, state_next;
    logic [ADDR_W-1:0] cnt_reg, cnt_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [COL_W-1:0]  shown_col_reg, shown_col_next;
    logic [ROW_W-1:0]  shown_row_reg, shown_row_next;

    logic              op_reg;
    logic [CHAR_W-1:0] code_reg;
    logic [CHAR_W-1:0] color_reg;
    logic              last_reg;
    logic              in_range_reg;

    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [CELL_W-1:0] rd_data_reg;

    // delayed write port: every memory write is registered here before it reaches the memory
    logic              pw_en_reg, pw_en_next;
    logic [ADDR_W-1:0] pw_addr_reg, pw_addr_next;
    logic [1:0]        pw_sel_reg, pw_sel_next;
    logic [CELL_W-1:0] pw_data;

    logic              m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic              load_out;

    logic [COL_W-1:0]  step_col;
    logic [ROW_W-1:0]  step_row;
    logic [ADDR_W-1:0] step_idx;
    cell_op_t          step_op;

    logic              accept;
    logic              scroll_copy;
    logic [CELL_W-1:0] out_cell;

    ctw_cursor_step #(
        .COLUMNS (COLUMNS),
        .COL_W   (COL_W),
        .ROW_W   (ROW_W),
        .ADDR_W  (ADDR_W)
    ) u_step (
        .cur_col   (col_reg),
        .cur_row   (row_reg),
        .char_code (code_reg),
        .nxt_col   (step_col),
        .nxt_row   (step_row),
        .cell_idx  (step_idx),
        .cell_op   (step_op)
    );

    // hold off while the last clearing write is still in flight
    assign s_tready    = (state_reg == ST_IDLE) && !pw_en_reg;
    assign accept      = s_tvalid && s_tready;
    assign scroll_copy = (cnt_reg < ADDR_W'(CELLS - COLUMNS));
    assign load_out    = (state_reg == ST_DONE) && (!m_tvalid_reg || m_tready);

    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        shown_col_next = shown_col_reg;
        shown_row_next = shown_row_reg;
        pw_en_next     = 1'b0;
        pw_addr_next   = pw_addr_reg;
        pw_sel_next    = pw_sel_reg;
        rd_en          = 1'b0;
        rd_addr        = ADDR_W'(s_tdata[16 +: IN_ADDR_W]);
        m_tvalid_next  = m_tvalid_reg && !m_tready;

        unique case (state_reg)
            ST_CLEAR: begin
                pw_en_next   = 1'b1;
                pw_addr_next = cnt_reg;
                pw_sel_next  = WSEL_ZERO;
                cnt_next     = cnt_reg + ADDR_W'(1);
                if (cnt_reg == ADDR_W'(CELLS - 1)) begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    if (s_tuser == OP_READ) begin
                        rd_en      = 1'b1;
                        state_next = ST_DONE;
                    end else if (row_reg == ROW_W'(ROWS)) begin
                        cnt_next   = '0;
                        state_next = ST_SCROLL;
                    end else begin
                        state_next = ST_CALC;
                    end
                end
            end
            ST_SCROLL: begin
                // copy the cell one row below, zero the bottom row
                rd_en        = scroll_copy;
                rd_addr      = cnt_reg + ADDR_W'(COLUMNS);
                pw_en_next   = 1'b1;
                pw_addr_next = cnt_reg;
                pw_sel_next  = scroll_copy ? WSEL_COPY : WSEL_ZERO;
                cnt_next     = cnt_reg + ADDR_W'(1);
                if (cnt_reg == ADDR_W'(CELLS - 1)) begin
                    cnt_next   = '0;
                    row_next   = ROW_W'(ROWS - 1);
                    state_next = ST_CALC;
                end
            end
            ST_CALC: begin
                // erase keeps the old attribute, so the cell is read first
                rd_en        = (step_op == CELL_ERASE);
                rd_addr      = step_idx;
                pw_en_next   = (step_op != CELL_NONE);
                pw_addr_next = step_idx;
                pw_sel_next  = (step_op == CELL_ERASE) ? WSEL_ERASE : WSEL_CHAR;
                col_next     = step_col;
                row_next     = step_row;
                if (last_reg) begin
                    shown_col_next = step_col;
                    shown_row_next = step_row;
                end
                state_next   = ST_DONE;
            end
            ST_DONE: begin
                if (load_out) begin
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        unique case (pw_sel_reg)
            WSEL_ZERO:  pw_data = '0;
            WSEL_COPY:  pw_data = rd_data_reg;
            WSEL_CHAR:  pw_data = {color_reg, code_reg};
            WSEL_ERASE: pw_data = {rd_data_reg[CELL_W-1:CHAR_W], {CHAR_W{1'b0}}};
            default:    pw_data = '0;
        endcase
    end

    assign out_cell = (op_reg == OP_READ && in_range_reg) ? rd_data_reg : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            cnt_reg       <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            shown_col_reg <= '0;
            shown_row_reg <= '0;
            pw_en_reg     <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            shown_col_reg <= shown_col_next;
            shown_row_reg <= shown_row_next;
            pw_en_reg     <= pw_en_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pw_addr_reg <= pw_addr_next;
        pw_sel_reg  <= pw_sel_next;
        if (accept) begin
            op_reg       <= s_tuser;
            code_reg     <= s_tdata[CHAR_W-1:0];
            color_reg    <= s_tdata[CHAR_W +: CHAR_W];
            last_reg     <= s_tlast;
            in_range_reg <= (32'(s_tdata[16 +: IN_ADDR_W]) < 32'(CELLS));
        end
        if (load_out) begin
            m_tdata_reg <= {OUT_ROW_W'(shown_row_reg), OUT_COL_W'(shown_col_reg),
                            OUT_ROW_W'(row_reg), OUT_COL_W'(col_reg), out_cell};
        end
    end

    always_ff @(posedge aclk) begin
        if (pw_en_reg) begin
            screen_mem[pw_addr_reg] <= pw_data;
        end
        if (rd_en) begin
            rd_data_reg <= screen_mem[rd_addr];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `CTW_ASSERT_ALWAYS(a_row_bound, row_reg <= ROW_W'(ROWS), "write row beyond scroll pending")
    `CTW_ASSERT_ALWAYS(a_col_bound, col_reg < COL_W'(COLUMNS), "write column out of range")
    `CTW_ASSERT_IMPLY(a_calc_after_scroll, state_reg == ST_CALC, row_reg < ROW_W'(ROWS),
        "character placed while scroll still pending")
    `CTW_ASSERT_IMPLY(a_valid_from_done, $rose(m_tvalid_reg), $past(state_reg) == ST_DONE,
        "result raised outside the final state")
    `CTW_ASSERT_IMPLY(a_no_write_in_idle_pipe, state_reg == ST_SCROLL, !s_tready,
        "item taken during a scroll pass")

endmodule
